### rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants for the byte run-length decoder: item layouts,
// result kinds and control-byte field geometry.
// ----------------------------------------------------------------------------
package brd_pkg;

  // Default width of the length accumulator
  localparam int LENGTH_BITS_DEFAULT = 32;

  // Control-byte geometry: type in the top bits, continuation, first value bits
  localparam int TYPE_BITS  = 2;
  localparam int FIRST_BITS = 7 - TYPE_BITS;
  localparam int MORE_BITS  = 7;
  localparam logic [MORE_BITS-1:0] SEVEN_MASK = 7'h7f;
  localparam logic [7:0] BYTE_MAX = 8'hff;

  // Width of the run length on the result channel
  localparam int RUN_LENGTH_W = 32;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_RUN        = 3'd0,
    KIND_LIT        = 3'd1,
    KIND_END_OK     = 3'd2,
    KIND_END_MID    = 3'd3,
    KIND_FORMAT_ERR = 3'd4
  } kind_t;

  // One input item
  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_data;
    logic       end_of_stream;
  } code_item_t;

  // One result item
  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              fill_value;
    logic [RUN_LENGTH_W-1:0] run_length;
  } cmd_item_t;

endpackage

### rtl/brd_stream_if.sv
// ----------------------------------------------------------------------------
// brd_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface brd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### rtl/byte_rle_delta_decoder.sv
// Results are registered: an accepted byte's result item is loaded into the output register.
// Throughput: one byte per cycle while no result is waiting or cmd.ready is high; the output register
// refills in the cycle it is taken, so code.ready follows cmd.ready whenever a result is waiting.
// Bytes that produce no result (varint bytes, fill- and literal-type control) leave the output register empty.
// Reset: synchronous rst returns the decoder to "expect first control byte",
// clears the accumulators and the error flag, and drops any pending result.
// ----------------------------------------------------------------------------
// byte_rle_delta_decoder
// Turns a control/data byte stream into (fill value, run length) add-commands,
// with varint run lengths, literal runs, format errors and end-of-stream status.
// ----------------------------------------------------------------------------
module byte_rle_delta_decoder
  import brd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  brd_stream_if.sink    code,
  brd_stream_if.source  cmd
);

  // Usable accumulator width: the limit never exceeds 32 bits
  localparam int AW = (LENGTH_BITS < RUN_LENGTH_W) ? LENGTH_BITS : RUN_LENGTH_W;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_MORE = 2'd1,
    PH_FILL = 2'd2,
    PH_LIT  = 2'd3
  } phase_t;

  typedef enum logic [TYPE_BITS-1:0] {
    RUN_ZERO    = 2'd0,
    RUN_FF      = 2'd1,
    RUN_FILL    = 2'd2,
    RUN_LITERAL = 2'd3
  } run_type_t;

  phase_t          phase, phase_next;
  run_type_t       run_type, run_type_next;
  logic [AW-1:0]   length_accum, length_accum_next;
  logic [AW-1:0]   literals_left, literals_left_next;
  logic            error_seen, error_seen_next;

  logic            out_valid;
  cmd_item_t       out_item;

  logic            accept;
  logic            emit;
  cmd_item_t       res;

  assign code.ready  = !out_valid || cmd.ready;
  assign accept      = code.valid && code.ready;
  assign cmd.valid   = out_valid;
  assign cmd.payload = out_item;

  // Decode one byte against the current phase
  always_comb begin
    logic [7:0]    b;
    logic          fail;
    logic          fin;
    logic [AW-1:0] fin_acc;
    logic [AW-1:0] len;
    logic [AW-1:0] lit_dec;

    b       = code.payload.code_byte;
    fail    = 1'b0;
    fin     = 1'b0;
    fin_acc = '0;
    len     = '0;
    lit_dec = '0;

    phase_next         = phase;
    run_type_next      = run_type;
    length_accum_next  = length_accum;
    literals_left_next = literals_left;
    error_seen_next    = error_seen;
    emit               = 1'b0;
    res                = '0;

    if (accept) begin
      if (code.payload.end_of_stream) begin
        // Report final status and return to reset state
        emit = 1'b1;
        if (error_seen) begin
          res.kind = KIND_FORMAT_ERR;
        end else if (phase != PH_CTRL) begin
          res.kind = KIND_END_MID;
        end else begin
          res.kind = KIND_END_OK;
        end
        phase_next         = PH_CTRL;
        run_type_next      = RUN_ZERO;
        length_accum_next  = '0;
        literals_left_next = '0;
        error_seen_next    = 1'b0;
      end else if (!error_seen) begin
        case (phase)
          PH_CTRL: begin
            if (code.payload.is_data) begin
              fail = 1'b1;
            end else begin
              run_type_next     = run_type_t'(b[7 -: TYPE_BITS]);
              fin_acc           = AW'(b[FIRST_BITS-1:0]);
              length_accum_next = fin_acc;
              if (b[FIRST_BITS]) begin
                phase_next = PH_MORE;
              end else begin
                fin = 1'b1;
              end
            end
          end
          PH_MORE: begin
            if (code.payload.is_data) begin
              fail = 1'b1;
            end else if (|length_accum[AW-1 -: MORE_BITS]) begin
              // Another seven bits would pass the length limit
              fail = 1'b1;
            end else begin
              fin_acc           = {length_accum[AW-MORE_BITS-1:0], b[MORE_BITS-1:0] & SEVEN_MASK};
              length_accum_next = fin_acc;
              if (!b[7]) begin
                fin = 1'b1;
              end
            end
          end
          PH_FILL: begin
            if (!code.payload.is_data) begin
              fail = 1'b1;
            end else begin
              emit           = 1'b1;
              res.kind       = KIND_RUN;
              res.fill_value = b;
              res.run_length = RUN_LENGTH_W'(length_accum);
              phase_next     = PH_CTRL;
            end
          end
          PH_LIT: begin
            if (!code.payload.is_data) begin
              fail = 1'b1;
            end else begin
              lit_dec            = (literals_left != '0) ? literals_left - AW'(1) : '0;
              literals_left_next = lit_dec;
              if (lit_dec == '0) begin
                phase_next = PH_CTRL;
              end
              emit           = 1'b1;
              res.kind       = KIND_LIT;
              res.fill_value = b;
              res.run_length = RUN_LENGTH_W'(1);
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase

        // Act on a completed varint value
        if (fin) begin
          if (&fin_acc) begin
            fail = 1'b1;
          end else begin
            len = fin_acc + AW'(1);
            case (run_type_next)
              RUN_ZERO: begin
                emit           = 1'b1;
                res.kind       = KIND_RUN;
                res.fill_value = '0;
                res.run_length = RUN_LENGTH_W'(len);
                phase_next     = PH_CTRL;
              end
              RUN_FF: begin
                emit           = 1'b1;
                res.kind       = KIND_RUN;
                res.fill_value = BYTE_MAX;
                res.run_length = RUN_LENGTH_W'(len);
                phase_next     = PH_CTRL;
              end
              RUN_FILL: begin
                length_accum_next = len;
                phase_next        = PH_FILL;
              end
              default: begin
                literals_left_next = len;
                phase_next         = PH_LIT;
              end
            endcase
          end
        end

        // Flag the format error and drop to control phase
        if (fail) begin
          emit            = 1'b1;
          res             = '0;
          res.kind        = KIND_FORMAT_ERR;
          error_seen_next = 1'b1;
          phase_next      = PH_CTRL;
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CTRL;
      run_type      <= RUN_ZERO;
      length_accum  <= '0;
      literals_left <= '0;
      error_seen    <= 1'b0;
    end else begin
      phase         <= phase_next;
      run_type      <= run_type_next;
      length_accum  <= length_accum_next;
      literals_left <= literals_left_next;
      error_seen    <= error_seen_next;
    end
  end

  // Load the result register when it is empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (code.ready) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (code.ready && emit) begin
      out_item <= res;
    end
  end

endmodule

### rtl/brd_checker.sv
// ----------------------------------------------------------------------------
// brd_checker
// Port-level checks for the byte run-length decoder, bound to the decoder module.
// ----------------------------------------------------------------------------
module brd_checker
  import brd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       code_valid,
  input logic       code_ready,
  input code_item_t code_payload,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input cmd_item_t  cmd_payload
);

  // A stalled result holds its value
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_payload))
    else $error("result changed while stalled");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !cmd_valid)
    else $error("result valid after reset");

  // An empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk)
    !cmd_valid |-> code_ready)
    else $error("input stalled with empty output");

  // A literal always covers one byte
  a_lit_len: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_payload.kind == KIND_LIT |-> cmd_payload.run_length == 32'd1)
    else $error("literal with length other than one");

  // End of stream reports a status on the next cycle
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_ready && code_payload.end_of_stream |=>
      cmd_valid && (cmd_payload.kind == KIND_END_OK || cmd_payload.kind == KIND_END_MID ||
                    cmd_payload.kind == KIND_FORMAT_ERR))
    else $error("end of stream without status");

endmodule

bind byte_rle_delta_decoder brd_checker u_brd_checker (
  .clk          (clk),
  .rst          (rst),
  .code_valid   (code.valid),
  .code_ready   (code.ready),
  .code_payload (code.payload),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_payload  (cmd.payload)
);
